/* rtl/ils_pkg.sv */
// shared types and constants of the interrupt latency statistics block
package ils_pkg;

  // item kinds
  localparam logic KIND_EVENT  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // field widths
  localparam int LINE_W = 4;
  localparam int LAT_W  = 32;
  localparam int CNT_W  = 32;
  localparam int SUM_W  = 64;
  localparam int TOT_W  = 36;
  localparam int MEAN_W = 40;
  localparam int FRAC_W = 8;

  // one table entry per interrupt line
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum;
    logic [LAT_W-1:0] worst;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller to datapath commands
  typedef struct packed {
    logic ev_accept;
    logic ev_write;
    logic rep_start;
    logic walk_read;
    logic load;
    logic overall;
    logic emit;
    logic next_line;
    logic clear;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last_line;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/ils_ram.sv */
// generic single-port-write ram with registered read
module ils_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ils_div.sv */
// iterative divider for the 32.8 fixed point mean, one quotient bit per cycle
module ils_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ils_pkg::SUM_W-1:0]  sum_i,
  input  logic [ils_pkg::TOT_W-1:0]  cnt_i,
  output logic                       done_o,
  output logic [ils_pkg::MEAN_W-1:0] quot_o
);

  localparam int STEPS  = ils_pkg::MEAN_W;
  localparam int STEP_W = $clog2(STEPS + 1);
  localparam int HALF_W = ils_pkg::SUM_W / 2;

  logic                       busy_q;
  logic                       done_q;
  logic [STEP_W-1:0]          step_q;
  logic [ils_pkg::TOT_W-1:0]  cnt_q;
  logic [ils_pkg::TOT_W-1:0]  rem_q;
  logic [ils_pkg::TOT_W-1:0]  rem_d;
  logic [ils_pkg::MEAN_W-1:0] dvd_q;
  logic [ils_pkg::MEAN_W-1:0] quo_q;
  logic [ils_pkg::TOT_W:0]    trial;
  logic [ils_pkg::TOT_W:0]    diff;
  logic                       fits;
  logic                       ovf;
  logic                       zero_cnt;

  // quotient would not fit 40 bits when the upper sum half reaches the count
  assign ovf      = {{(ils_pkg::TOT_W-HALF_W){1'b0}}, sum_i[ils_pkg::SUM_W-1:HALF_W]} >= cnt_i;
  assign zero_cnt = (cnt_i == '0);

  // restoring step
  assign trial = {rem_q, dvd_q[ils_pkg::MEAN_W-1]};
  assign diff  = trial - {1'b0, cnt_q};
  assign fits  = trial >= {1'b0, cnt_q};
  assign rem_d = fits ? diff[ils_pkg::TOT_W-1:0] : trial[ils_pkg::TOT_W-1:0];

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (zero_cnt || ovf) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          step_q <= STEP_W'(STEPS);
        end
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder, dividend bits and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cnt_q <= cnt_i;
      rem_q <= {{(ils_pkg::TOT_W-HALF_W){1'b0}}, sum_i[ils_pkg::SUM_W-1:HALF_W]};
      dvd_q <= {sum_i[HALF_W-1:0], {ils_pkg::FRAC_W{1'b0}}};
      quo_q <= (!zero_cnt && ovf) ? '1 : '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[ils_pkg::MEAN_W-2:0], 1'b0};
      quo_q <= {quo_q[ils_pkg::MEAN_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* rtl/ils_datapath.sv */
// datapath: line table, entry update, totals, divider and output register
module ils_datapath #(
  parameter int NUM_LINES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ils_pkg::dp_cmd_t            cmd_i,
  output ils_pkg::dp_status_t         status_o,
  input  logic [ils_pkg::LINE_W-1:0]  irq_line_i,
  input  logic [ils_pkg::LAT_W-1:0]   latency_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic                        is_overall_o,
  output logic [ils_pkg::LINE_W-1:0]  line_index_o,
  output logic [ils_pkg::TOT_W-1:0]   event_total_o,
  output logic [ils_pkg::MEAN_W-1:0]  mean_latency_o,
  output logic [ils_pkg::LAT_W-1:0]   max_latency_o,
  output logic                        last_o
);

  localparam int AW = $clog2(NUM_LINES);

  logic [AW-1:0]                ev_addr_q;
  logic                         ev_ok_q;
  logic [ils_pkg::LAT_W-1:0]    lat_q;
  logic [AW-1:0]                idx_q;
  logic [AW-1:0]                raddr;
  logic                         ram_re;
  logic                         ram_we;
  logic [NUM_LINES-1:0]         vld_q;
  logic                         rd_vld_q;
  logic [ils_pkg::ENTRY_W-1:0]  rdata;
  ils_pkg::entry_t              rd_ent;
  ils_pkg::entry_t              old_ent;
  ils_pkg::entry_t              new_ent;
  logic [ils_pkg::SUM_W:0]      ev_sum;
  logic [ils_pkg::TOT_W-1:0]    tot_cnt_q;
  logic [ils_pkg::SUM_W-1:0]    tot_sum_q;
  logic [ils_pkg::LAT_W-1:0]    tot_worst_q;
  logic [ils_pkg::SUM_W:0]      acc_sum;
  logic [ils_pkg::TOT_W-1:0]    op_cnt;
  logic [ils_pkg::SUM_W-1:0]    op_sum;
  logic [ils_pkg::LAT_W-1:0]    op_worst;
  logic [ils_pkg::TOT_W-1:0]    hold_cnt_q;
  logic [ils_pkg::LAT_W-1:0]    hold_worst_q;
  logic                         div_done;
  logic [ils_pkg::MEAN_W-1:0]   div_quot;
  logic                         out_valid_q;
  logic                         is_overall_q;
  logic [ils_pkg::LINE_W-1:0]   line_index_q;
  logic [ils_pkg::TOT_W-1:0]    event_total_q;
  logic [ils_pkg::MEAN_W-1:0]   mean_latency_q;
  logic [ils_pkg::LAT_W-1:0]    max_latency_q;
  logic                         last_q;

  // table port selection
  assign raddr  = cmd_i.walk_read ? idx_q : AW'(irq_line_i);
  assign ram_re = cmd_i.ev_accept | cmd_i.walk_read;
  assign ram_we = cmd_i.ev_write & ev_ok_q;

  ils_ram #(
    .WIDTH (ils_pkg::ENTRY_W),
    .DEPTH (NUM_LINES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ev_addr_q),
    .wdata_i (new_ent),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // entries never written since the last clear read as zero
  assign rd_ent  = ils_pkg::entry_t'(rdata);
  assign old_ent = rd_vld_q ? rd_ent : '0;

  // event update with saturating count and sum
  assign ev_sum = {1'b0, old_ent.sum} + {{(ils_pkg::SUM_W-ils_pkg::LAT_W+1){1'b0}}, lat_q};
  always_comb begin
    new_ent.count = (old_ent.count == '1) ? old_ent.count
                                          : old_ent.count + ils_pkg::CNT_W'(1);
    new_ent.sum   = ev_sum[ils_pkg::SUM_W] ? '1 : ev_sum[ils_pkg::SUM_W-1:0];
    new_ent.worst = (lat_q > old_ent.worst) ? lat_q : old_ent.worst;
  end

  // operands of one report result
  always_comb begin
    if (cmd_i.overall) begin
      op_cnt   = tot_cnt_q;
      op_sum   = tot_sum_q;
      op_worst = tot_worst_q;
    end else begin
      op_cnt   = {{(ils_pkg::TOT_W-ils_pkg::CNT_W){1'b0}}, old_ent.count};
      op_sum   = old_ent.sum;
      op_worst = old_ent.worst;
    end
  end

  assign acc_sum = {1'b0, tot_sum_q} + {1'b0, old_ent.sum};

  ils_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.load),
    .sum_i   (op_sum),
    .cnt_i   (op_cnt),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // control state: valid bits, walk index, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ram_re) begin
        rd_vld_q <= vld_q[raddr];
      end
      if (cmd_i.clear) begin
        vld_q <= '0;
      end else if (ram_we) begin
        vld_q[ev_addr_q] <= 1'b1;
      end
      if (cmd_i.rep_start) begin
        idx_q <= '0;
      end else if (cmd_i.next_line) begin
        idx_q <= idx_q + AW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload: captured event, totals, operands and result item
  always_ff @(posedge clk_i) begin
    if (cmd_i.ev_accept) begin
      ev_addr_q <= AW'(irq_line_i);
      ev_ok_q   <= (32'(irq_line_i) < 32'(NUM_LINES));
      lat_q     <= latency_i;
    end
    if (cmd_i.rep_start) begin
      tot_cnt_q   <= '0;
      tot_sum_q   <= '0;
      tot_worst_q <= '0;
    end else if (cmd_i.load && !cmd_i.overall) begin
      tot_cnt_q   <= tot_cnt_q + op_cnt;
      tot_sum_q   <= acc_sum[ils_pkg::SUM_W] ? '1 : acc_sum[ils_pkg::SUM_W-1:0];
      tot_worst_q <= (old_ent.worst > tot_worst_q) ? old_ent.worst : tot_worst_q;
    end
    if (cmd_i.load) begin
      hold_cnt_q   <= op_cnt;
      hold_worst_q <= op_worst;
    end
    if (cmd_i.emit) begin
      is_overall_q   <= cmd_i.overall;
      line_index_q   <= cmd_i.overall ? '0 : ils_pkg::LINE_W'(idx_q);
      event_total_q  <= hold_cnt_q;
      mean_latency_q <= div_quot;
      max_latency_q  <= hold_worst_q;
      last_q         <= cmd_i.overall;
    end
  end

  // status back to the controller
  assign status_o.last_line = (idx_q == AW'(NUM_LINES - 1));
  assign status_o.div_done  = div_done;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign is_overall_o   = is_overall_q;
  assign line_index_o   = line_index_q;
  assign event_total_o  = event_total_q;
  assign mean_latency_o = mean_latency_q;
  assign max_latency_o  = max_latency_q;
  assign last_o         = last_q;

endmodule

/* rtl/ils_ctrl.sv */
// controller: sequences event updates and report walks
module ils_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                kind_i,
  output logic                in_stall_o,
  input  ils_pkg::dp_status_t status_i,
  output ils_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_READ,
    S_LOAD,
    S_DIVIDE,
    S_EMIT
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   ovr_q;
  logic   ovr_d;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    ovr_d         = ovr_q;
    cmd_o         = '0;
    cmd_o.overall = ovr_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (kind_i == ils_pkg::KIND_EVENT) begin
            cmd_o.ev_accept = 1'b1;
            state_d         = S_UPDATE;
          end else begin
            cmd_o.rep_start = 1'b1;
            ovr_d           = 1'b0;
            state_d         = S_READ;
          end
        end
      end
      S_UPDATE: begin
        cmd_o.ev_write = 1'b1;
        state_d        = S_IDLE;
      end
      S_READ: begin
        cmd_o.walk_read = 1'b1;
        state_d         = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (status_i.div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (ovr_q) begin
            cmd_o.clear = 1'b1;
            ovr_d       = 1'b0;
            state_d     = S_IDLE;
          end else if (status_i.last_line) begin
            ovr_d   = 1'b1;
            state_d = S_LOAD;
          end else begin
            cmd_o.next_line = 1'b1;
            state_d         = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovr_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ovr_q   <= ovr_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

/* rtl/irq_latency_statistics.sv */
// top level of the interrupt latency statistics block
// An event item reads its line's table entry from the table RAM and then writes back the
// updated count, sum and worst latency. A report item produces NUM_LINES per-line results
// and then the overall result flagged last; each per-line result takes a table read, a load
// of the bit-serial mean divider, a wait on the divider and an emit once the output register
// is free, and the overall result skips the table read. Tables clear at the end of a report
// through per-line valid bits, so no clearing pass runs after reset. New items are taken
// while the last result waits in the output register.
module irq_latency_statistics #(
  parameter int NUM_LINES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [ils_pkg::LINE_W-1:0]  irq_line_i,
  input  logic [ils_pkg::LAT_W-1:0]   latency_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        is_overall_o,
  output logic [ils_pkg::LINE_W-1:0]  line_index_o,
  output logic [ils_pkg::TOT_W-1:0]   event_total_o,
  output logic [ils_pkg::MEAN_W-1:0]  mean_latency_o,
  output logic [ils_pkg::LAT_W-1:0]   max_latency_o,
  output logic                        last_o
);

  ils_pkg::dp_cmd_t    cmd;
  ils_pkg::dp_status_t status;

  // sequencing
  ils_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // tables and arithmetic
  ils_datapath #(
    .NUM_LINES (NUM_LINES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .irq_line_i     (irq_line_i),
    .latency_i      (latency_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .is_overall_o   (is_overall_o),
    .line_index_o   (line_index_o),
    .event_total_o  (event_total_o),
    .mean_latency_o (mean_latency_o),
    .max_latency_o  (max_latency_o),
    .last_o         (last_o)
  );

  // the last flag marks exactly the overall result
  a_last_is_overall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == is_overall_o))
    else $error("last flag and overall flag disagree");

  // overall result reports line index zero
  a_overall_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_overall_o) |-> (line_index_o == '0))
    else $error("overall result with nonzero line index");

  // empty count gives zero mean
  a_empty_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_total_o == '0)) |-> (mean_latency_o == '0))
    else $error("nonzero mean for empty count");

  // an accepted item keeps the input stalled in the following cycle
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted on consecutive cycles");

endmodule
